[hdl/gcr_pkg.sv]
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants for the six-and-two GCR sector encoder.
// ----------------------------------------------------------------------------
package gcr_pkg;

   // payload widths
   localparam int FUNC_W   = 2;
   localparam int TRACK_W  = 6;
   localparam int SECTOR_W = 4;
   localparam int BYTE_W   = 8;
   localparam int SIX_W    = 6;

   // sector geometry
   localparam int SECTOR_BYTES  = 256;
   localparam int TWO_BIT_COUNT = (SECTOR_BYTES + 2) / 3;                   // 86
   localparam int C_DEPTH       = SECTOR_BYTES - 2 * TWO_BIT_COUNT;         // 84
   localparam int STORE_AW      = $clog2(SECTOR_BYTES);
   localparam int LOAD_W        = STORE_AW + 1;
   localparam int TWO_AW        = $clog2(TWO_BIT_COUNT);

   // nibble positions in the sector image
   localparam int IMAGE_LEN   = 374;
   localparam int POS_W       = $clog2(IMAGE_LEN);
   localparam int DATA_START  = 28;
   localparam int SIX_BIT_END = 370;
   localparam int LAST_POS    = IMAGE_LEN - 1;

   // disk marks
   localparam logic [7:0] SYNC_BYTE  = 8'hFF;
   localparam logic [7:0] MARK_D5    = 8'hD5;
   localparam logic [7:0] MARK_AA    = 8'hAA;
   localparam logic [7:0] ADDR_MARK  = 8'h96;
   localparam logic [7:0] DATA_MARK  = 8'hAD;
   localparam logic [7:0] TRAIL_DE   = 8'hDE;
   localparam logic [7:0] TRAIL_EB   = 8'hEB;
   localparam logic [7:0] HALF_MASK  = 8'hAA;
   localparam logic [7:0] VOLUME_RST = 8'd254;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_START = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] index;
      logic [BYTE_W-1:0]   data;
   } load_type;

   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] k;    // six-bit value number, position minus data start
   } fetch_type;

   localparam logic [7:0] GCR_TABLE [64] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

endpackage

[hdl/gcr_req_if.sv]
// ----------------------------------------------------------------------------
// gcr_req_if
// Request channel: function code plus start and load payload.
// ----------------------------------------------------------------------------
interface gcr_req_if;
   logic                         valid;
   logic                         ready;
   logic [gcr_pkg::FUNC_W-1:0]   func;
   logic [gcr_pkg::TRACK_W-1:0]  track;
   logic [gcr_pkg::SECTOR_W-1:0] sector;
   logic [gcr_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, func, track, sector, data_byte, input ready);
   modport sink   (input valid, func, track, sector, data_byte, output ready);
endinterface

[hdl/gcr_rsp_if.sv]
// ----------------------------------------------------------------------------
// gcr_rsp_if
// Response channel: one encoded disk nibble per word.
// ----------------------------------------------------------------------------
interface gcr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gcr_pkg::BYTE_W-1:0] nibble;
   logic                       end_of_sector;

   modport source (output valid, nibble, end_of_sector, input ready);
   modport sink   (input valid, nibble, end_of_sector, output ready);
endinterface

[hdl/gcr_sector_store.sv]
// ----------------------------------------------------------------------------
// gcr_sector_store
// Sector byte store split for one-read access: the upper six bits of each
// byte in one memory, the low two bits in three memories, one per third.
// ----------------------------------------------------------------------------
module gcr_sector_store (
   input  logic                        clock,
   input  gcr_pkg::load_type           load,
   input  gcr_pkg::fetch_type          fetch,
   output logic [gcr_pkg::SIX_W-1:0]   raw
);

   logic [gcr_pkg::SIX_W-1:0] hi_mem [0:gcr_pkg::SECTOR_BYTES-1];
   logic [1:0]                a_mem  [0:gcr_pkg::TWO_BIT_COUNT-1];
   logic [1:0]                b_mem  [0:gcr_pkg::TWO_BIT_COUNT-1];
   logic [1:0]                c_mem  [0:gcr_pkg::C_DEPTH-1];

   logic [gcr_pkg::STORE_AW-1:0] wr_b_full;
   logic [gcr_pkg::STORE_AW-1:0] wr_c_full;
   logic [gcr_pkg::TWO_AW-1:0]   wr_b_idx;
   logic [gcr_pkg::TWO_AW-1:0]   wr_c_idx;
   logic                         wr_in_a;
   logic                         wr_in_b;

   logic                         rd_two;
   logic [gcr_pkg::POS_W-1:0]    rd_hi_full;
   logic [gcr_pkg::STORE_AW-1:0] rd_hi_idx;
   logic [gcr_pkg::TWO_AW-1:0]   rd_two_idx;
   logic                         rd_c_zero;
   logic [gcr_pkg::TWO_AW-1:0]   rd_c_idx;

   logic [gcr_pkg::SIX_W-1:0]    hi_rd_ff;
   logic [1:0]                   a_rd_ff;
   logic [1:0]                   b_rd_ff;
   logic [1:0]                   c_rd_ff;
   logic                         two_sel_ff;
   logic                         c_zero_ff;

   // write side: which third of the sector holds the low two bits
   always_comb begin
      wr_in_a   = load.index < gcr_pkg::STORE_AW'(gcr_pkg::TWO_BIT_COUNT);
      wr_in_b   = load.index < gcr_pkg::STORE_AW'(2 * gcr_pkg::TWO_BIT_COUNT);
      wr_b_full = load.index - gcr_pkg::STORE_AW'(gcr_pkg::TWO_BIT_COUNT);
      wr_c_full = load.index - gcr_pkg::STORE_AW'(2 * gcr_pkg::TWO_BIT_COUNT);
      wr_b_idx  = wr_b_full[gcr_pkg::TWO_AW-1:0];
      wr_c_idx  = wr_c_full[gcr_pkg::TWO_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (load.en) begin
         hi_mem[load.index] <= load.data[7:2];
         if (wr_in_a) begin
            a_mem[load.index[gcr_pkg::TWO_AW-1:0]] <= load.data[1:0];
         end else if (wr_in_b) begin
            b_mem[wr_b_idx] <= load.data[1:0];
         end else begin
            c_mem[wr_c_idx] <= load.data[1:0];
         end
      end
   end

   // read side: two-bit values come from all three thirds at once; the
   // last third is short, its missing entries stand for bytes 256 and 257
   always_comb begin
      rd_two     = fetch.k < gcr_pkg::POS_W'(gcr_pkg::TWO_BIT_COUNT);
      rd_hi_full = fetch.k - gcr_pkg::POS_W'(gcr_pkg::TWO_BIT_COUNT);
      rd_hi_idx  = rd_two ? '0 : rd_hi_full[gcr_pkg::STORE_AW-1:0];
      rd_two_idx = rd_two ? fetch.k[gcr_pkg::TWO_AW-1:0] : '0;
      rd_c_zero  = rd_two_idx >= gcr_pkg::TWO_AW'(gcr_pkg::C_DEPTH);
      rd_c_idx   = rd_c_zero ? '0 : rd_two_idx;
   end

   always_ff @(posedge clock) begin
      if (fetch.en) begin
         hi_rd_ff   <= hi_mem[rd_hi_idx];
         a_rd_ff    <= a_mem[rd_two_idx];
         b_rd_ff    <= b_mem[rd_two_idx];
         c_rd_ff    <= c_mem[rd_c_idx];
         two_sel_ff <= rd_two;
         c_zero_ff  <= rd_c_zero;
      end
   end

   logic [1:0] c_bits;
   assign c_bits = c_zero_ff ? 2'b00 : c_rd_ff;

   // two-bit pairs go out with their bits swapped
   assign raw = two_sel_ff ? {c_bits[0], c_bits[1], b_rd_ff[0], b_rd_ff[1],
                              a_rd_ff[0], a_rd_ff[1]}
                           : hi_rd_ff;

endmodule

[hdl/gcr_six_and_two_sector_encoder_core.sv]
// ----------------------------------------------------------------------------
// gcr_six_and_two_sector_encoder_core
// Builds the 374-nibble disk image of one sector: sync, address field,
// six-and-two coded data field with chained checksum, trailer marks.
// ----------------------------------------------------------------------------
//   port        dir   role
//   req_port    in    start / load byte / read next nibble, valid-ready
//   rsp_port    out   one nibble word per read, valid-ready
//   csr_*       in    volume register write
//
// One request word per cycle while req_port.ready stays high. The store read register loads
// at the edge that accepts a read word; the code and translate logic fills the output register
// from it at the first edge where that register is free, and the nibble then shows on rsp_port.
// Start and load words give no response. Reset clears positions,
// latches and volume (254); store contents stay undefined until loaded. A
// stalled rsp_port holds the output register; a read word then waiting in the
// fetch stage drops req_port.ready until the output register frees.
// ----------------------------------------------------------------------------
module gcr_six_and_two_sector_encoder_core (
   input  logic                        clock,
   input  logic                        reset,
   gcr_req_if.sink                     req_port,
   gcr_rsp_if.source                   rsp_port,
   input  logic                        csr_write_enable,
   input  logic [gcr_pkg::BYTE_W-1:0]  csr_write_data
);

   logic [gcr_pkg::BYTE_W-1:0]   volume_ff;
   logic [gcr_pkg::TRACK_W-1:0]  track_ff;
   logic [gcr_pkg::SECTOR_W-1:0] sector_ff;
   logic [gcr_pkg::LOAD_W-1:0]   load_index_ff;
   logic [gcr_pkg::POS_W-1:0]    read_pos_ff;
   logic [gcr_pkg::POS_W-1:0]    read_pos_in;
   logic [gcr_pkg::SIX_W-1:0]    chain_ff;
   logic [gcr_pkg::SIX_W-1:0]    chain_in;
   logic                         fetch_valid_ff;
   logic [gcr_pkg::POS_W-1:0]    fetch_pos_ff;
   logic                         rsp_valid_ff;
   logic [gcr_pkg::BYTE_W-1:0]   rsp_nibble_ff;
   logic [gcr_pkg::BYTE_W-1:0]   rsp_nibble_in;
   logic                         rsp_eos_ff;

   logic                         accept;
   logic                         is_start;
   logic                         is_load;
   logic                         is_read;
   logic                         rsp_free;
   logic                         fetch_adv;
   logic                         in_data;
   logic [gcr_pkg::SIX_W-1:0]    raw;
   logic [gcr_pkg::SIX_W-1:0]    prev;
   logic [gcr_pkg::BYTE_W-1:0]   sum;

   gcr_pkg::load_type            load;
   gcr_pkg::fetch_type           fetch;

   function automatic logic [7:0] odd_half(input logic [7:0] v);
      return (v >> 1) | gcr_pkg::HALF_MASK;
   endfunction

   function automatic logic [7:0] even_half(input logic [7:0] v);
      return v | gcr_pkg::HALF_MASK;
   endfunction

   // handshake
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;
   assign fetch_adv      = fetch_valid_ff && rsp_free;
   assign req_port.ready = !fetch_valid_ff || rsp_free;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      is_start = 1'b0;
      is_load  = 1'b0;
      is_read  = 1'b0;
      unique case (req_port.func)
         gcr_pkg::FUNC_START: is_start = accept;
         gcr_pkg::FUNC_LOAD:  is_load  = accept;
         gcr_pkg::FUNC_READ:  is_read  = accept;
         default: ;
      endcase
   end

   // store access
   always_comb begin
      load.en    = is_load && (load_index_ff < gcr_pkg::LOAD_W'(gcr_pkg::SECTOR_BYTES));
      load.index = load_index_ff[gcr_pkg::STORE_AW-1:0];
      load.data  = req_port.data_byte;
      fetch.en   = is_read;
      fetch.k    = read_pos_ff - gcr_pkg::POS_W'(gcr_pkg::DATA_START);
   end

   gcr_sector_store u_store (
      .clock (clock),
      .load  (load),
      .fetch (fetch),
      .raw   (raw)
   );

   assign read_pos_in = (read_pos_ff == gcr_pkg::POS_W'(gcr_pkg::LAST_POS))
                        ? '0 : read_pos_ff + 1'b1;

   // nibble coding for the word in the fetch stage
   always_comb begin
      sum      = volume_ff ^ {2'b00, track_ff} ^ {4'b0000, sector_ff};
      in_data  = (fetch_pos_ff >= gcr_pkg::POS_W'(gcr_pkg::DATA_START)) &&
                 (fetch_pos_ff <  gcr_pkg::POS_W'(gcr_pkg::SIX_BIT_END));
      // chain restarts at the first data nibble
      prev     = (fetch_pos_ff == gcr_pkg::POS_W'(gcr_pkg::DATA_START)) ? '0 : chain_ff;
      chain_in = chain_ff;
      if (in_data) begin
         chain_in      = raw;
         rsp_nibble_in = gcr_pkg::GCR_TABLE[prev ^ raw];
      end else begin
         case (fetch_pos_ff) inside
            9'd6, 9'd25:                rsp_nibble_in = gcr_pkg::MARK_D5;
            9'd7, 9'd18, 9'd26, 9'd372: rsp_nibble_in = gcr_pkg::MARK_AA;
            9'd8:                       rsp_nibble_in = gcr_pkg::ADDR_MARK;
            9'd9:                       rsp_nibble_in = odd_half(volume_ff);
            9'd10:                      rsp_nibble_in = even_half(volume_ff);
            9'd11:                      rsp_nibble_in = odd_half({2'b00, track_ff});
            9'd12:                      rsp_nibble_in = even_half({2'b00, track_ff});
            9'd13:                      rsp_nibble_in = odd_half({4'b0000, sector_ff});
            9'd14:                      rsp_nibble_in = even_half({4'b0000, sector_ff});
            9'd15:                      rsp_nibble_in = odd_half(sum);
            9'd16:                      rsp_nibble_in = even_half(sum);
            9'd17, 9'd371:              rsp_nibble_in = gcr_pkg::TRAIL_DE;
            9'd19, 9'd373:              rsp_nibble_in = gcr_pkg::TRAIL_EB;
            9'd27:                      rsp_nibble_in = gcr_pkg::DATA_MARK;
            9'd370:                     rsp_nibble_in = gcr_pkg::GCR_TABLE[chain_ff];
            default:                    rsp_nibble_in = gcr_pkg::SYNC_BYTE;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff      <= gcr_pkg::VOLUME_RST;
         track_ff       <= '0;
         sector_ff      <= '0;
         load_index_ff  <= '0;
         read_pos_ff    <= '0;
         chain_ff       <= '0;
         fetch_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            volume_ff <= csr_write_data;
         end
         // a start accepted at the same edge is younger than the fetched read
         if (is_start) begin
            chain_ff <= '0;
         end else if (fetch_adv) begin
            chain_ff <= chain_in;
         end
         if (is_start) begin
            track_ff      <= req_port.track;
            sector_ff     <= req_port.sector;
            load_index_ff <= '0;
            read_pos_ff   <= '0;
         end
         if (load.en) begin
            load_index_ff <= load_index_ff + 1'b1;
         end
         if (is_read) begin
            read_pos_ff <= read_pos_in;
         end
         if (is_read) begin
            fetch_valid_ff <= 1'b1;
         end else if (fetch_adv) begin
            fetch_valid_ff <= 1'b0;
         end
         if (fetch_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (is_read) begin
         fetch_pos_ff <= read_pos_ff;
      end
      if (fetch_adv) begin
         rsp_nibble_ff <= rsp_nibble_in;
         rsp_eos_ff    <= fetch_pos_ff == gcr_pkg::POS_W'(gcr_pkg::LAST_POS);
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.nibble        = rsp_nibble_ff;
   assign rsp_port.end_of_sector = rsp_eos_ff;

endmodule

[tb/gcr_six_and_two_sector_encoder_core_tb.sv]
// ----------------------------------------------------------------------------
// gcr_six_and_two_sector_encoder_core_tb
// Self-checking bench for the six-and-two sector encoder. Request words come
// from a queue through a valid-ready driver with random send gaps. Each
// accepted word updates a behavioral encoder that predicts the nibble stream.
// A monitor stalls the response side at random and checks every nibble word.
// ----------------------------------------------------------------------------
module gcr_six_and_two_sector_encoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [gcr_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int NIBBLES_PER_SECTOR = 374;
   localparam int FIRST_DATA_POS     = 28;
   localparam int CHECKSUM_POS       = 370;
   localparam int LOW_BIT_GROUPS     = 86;
   localparam int STORE_BYTES        = 256;
   localparam int WATCHDOG_LIMIT     = 4000;
   localparam int SETTLE_CYCLES      = 8;

   localparam logic [7:0] SYNC_FF = 8'hFF;
   localparam logic [7:0] MARK_D5 = 8'hD5;
   localparam logic [7:0] MARK_AA = 8'hAA;
   localparam logic [7:0] ADDR_96 = 8'h96;
   localparam logic [7:0] DATA_AD = 8'hAD;
   localparam logic [7:0] TAIL_DE = 8'hDE;
   localparam logic [7:0] TAIL_EB = 8'hEB;

   // 6-bit value to disk byte
   localparam logic [7:0] XLATE [64] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

   typedef struct {
      logic [gcr_pkg::FUNC_W-1:0]   func;
      logic [gcr_pkg::TRACK_W-1:0]  track;
      logic [gcr_pkg::SECTOR_W-1:0] sector;
      logic [gcr_pkg::BYTE_W-1:0]   data_byte;
      bit                           drain;   // hold until all nibbles are back
   } request_word_type;

   typedef struct {
      logic [7:0] nibble;
      logic       last;
      int         pos;
   } nibble_word_type;

   logic clock;
   logic reset;
   logic                        csr_write_enable;
   logic [gcr_pkg::BYTE_W-1:0]  csr_write_data;

   gcr_req_if req_bus ();
   gcr_rsp_if rsp_bus ();

   gcr_six_and_two_sector_encoder_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   request_word_type requests_pending [$];
   request_word_type held_word;
   nibble_word_type  nibbles_due [$];

   // encoder state
   logic [7:0] image_bytes [STORE_BYTES];
   int         load_count;
   int         read_pos;
   logic [5:0] chain_q;
   logic [5:0] track_q;
   logic [3:0] sector_q;
   logic [7:0] volume_q;

   int  items_queued  = 0;
   int  items_taken   = 0;
   int  reads_issued  = 0;
   int  nibbles_seen  = 0;
   int  starts_seen   = 0;
   int  wraps_seen    = 0;
   int  error_count   = 0;
   int  send_gap      = 0;
   int  stall_left    = 0;
   int  quiet_cycles  = 0;
   bit  calm          = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic logic [7:0] stored_byte(input int idx);
      if (idx >= STORE_BYTES)
         return 8'h00;
      return image_bytes[idx];
   endfunction

   // unchained six-bit value number k of the data field
   function automatic logic [5:0] six_bit_value(input int k);
      logic [7:0] a, b, c;
      if (k >= LOW_BIT_GROUPS) begin
         a = stored_byte(k - LOW_BIT_GROUPS);
         return a[7:2];
      end
      a = stored_byte(k);
      b = stored_byte(k + LOW_BIT_GROUPS);
      c = stored_byte(k + 2 * LOW_BIT_GROUPS);
      // low two bits of each byte go in swapped
      return {c[0], c[1], b[0], b[1], a[0], a[1]};
   endfunction

   function automatic logic [7:0] odd_half(input logic [7:0] v);
      return (v >> 1) | 8'hAA;
   endfunction

   function automatic logic [7:0] even_half(input logic [7:0] v);
      return v | 8'hAA;
   endfunction

   function automatic logic [7:0] encode_nibble(input int p);
      logic [7:0] sum;
      logic [5:0] v, prev;
      sum = volume_q ^ {2'b00, track_q} ^ {4'b0000, sector_q};
      if (p >= FIRST_DATA_POS && p < CHECKSUM_POS) begin
         v = six_bit_value(p - FIRST_DATA_POS);
         prev = (p == FIRST_DATA_POS) ? 6'd0 : chain_q;
         chain_q = v;
         return XLATE[prev ^ v];
      end
      case (p)
         6, 25:             return MARK_D5;
         7, 18, 26, 372:    return MARK_AA;
         8:                 return ADDR_96;
         9:                 return odd_half(volume_q);
         10:                return even_half(volume_q);
         11:                return odd_half({2'b00, track_q});
         12:                return even_half({2'b00, track_q});
         13:                return odd_half({4'b0000, sector_q});
         14:                return even_half({4'b0000, sector_q});
         15:                return odd_half(sum);
         16:                return even_half(sum);
         17, 371:           return TAIL_DE;
         19, 373:           return TAIL_EB;
         27:                return DATA_AD;
         CHECKSUM_POS:      return XLATE[chain_q];
         default:           return SYNC_FF;
      endcase
   endfunction

   function automatic void encode_request(input request_word_type w);
      int              p;
      nibble_word_type due;
      case (w.func)
         gcr_pkg::FUNC_START: begin
            track_q    = w.track;
            sector_q   = w.sector;
            load_count = 0;
            read_pos   = 0;
            chain_q    = 6'd0;
            starts_seen++;
         end
         gcr_pkg::FUNC_LOAD: begin
            if (load_count < STORE_BYTES) begin
               image_bytes[load_count] = w.data_byte;
               load_count++;
            end
         end
         gcr_pkg::FUNC_READ: begin
            p = (read_pos >= NIBBLES_PER_SECTOR) ? 0 : read_pos;
            due.nibble = encode_nibble(p);
            due.last   = (p == NIBBLES_PER_SECTOR - 1);
            due.pos    = p;
            nibbles_due.push_back(due);
            if (due.last) begin
               read_pos = 0;
               wraps_seen++;
            end else begin
               read_pos = p + 1;
            end
         end
         default: ;
      endcase
   endfunction

   // request driver, also owns the encoder state
   always @(posedge clock) begin
      bit read_now;
      read_now = 1'b0;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.func      <= gcr_pkg::FUNC_START;
         req_bus.track     <= '0;
         req_bus.sector    <= '0;
         req_bus.data_byte <= '0;
         send_gap   = 0;
         load_count = 0;
         read_pos   = 0;
         chain_q    = 6'd0;
         track_q    = 6'd0;
         sector_q   = 4'd0;
         volume_q   = 8'd254;
      end else begin
         if (csr_write_enable)
            volume_q = csr_write_data;
         if (req_bus.valid && req_bus.ready) begin
            read_now = (held_word.func == gcr_pkg::FUNC_READ);
            encode_request(held_word);
            items_taken <= items_taken + 1;
            if (read_now)
               reads_issued <= reads_issued + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap == 0 && !calm && $urandom_range(0, 19) == 0)
               send_gap = $urandom_range(1, 16);
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (requests_pending.size() != 0 &&
                         !(requests_pending[0].drain &&
                           (read_now || reads_issued != nibbles_seen))) begin
               held_word = requests_pending.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.func      <= held_word.func;
               req_bus.track     <= held_word.track;
               req_bus.sector    <= held_word.sector;
               req_bus.data_byte <= held_word.data_byte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      nibble_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            nibbles_seen <= nibbles_seen + 1;
            if (nibbles_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word, nibble %02h", rsp_bus.nibble));
            end else begin
               want = nibbles_due.pop_front();
               if (rsp_bus.nibble !== want.nibble)
                  report_mismatch($sformatf("pos %0d nibble %02h, want %02h",
                                            want.pos, rsp_bus.nibble, want.nibble));
               if (rsp_bus.end_of_sector !== want.last)
                  report_mismatch($sformatf("pos %0d end_of_sector %b, want %b",
                                            want.pos, rsp_bus.end_of_sector, want.last));
            end
         end
         if (stall_left == 0 && !calm && $urandom_range(0, 19) == 0)
            stall_left = $urandom_range(1, 16);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_word(input logic [1:0] f, input logic [5:0] t,
                             input logic [3:0] s, input logic [7:0] d, input bit drain);
      request_word_type w;
      w.func      = f;
      w.track     = t;
      w.sector    = s;
      w.data_byte = d;
      w.drain     = drain;
      requests_pending.push_back(w);
      items_queued++;
   endtask

   // a start, then reads mixed with loads and a little noise
   task automatic queue_sector_pass(input int reads_wanted, inout int counted);
      int         reads, r;
      logic [5:0] t;
      logic [3:0] s;
      t = 6'($urandom);
      s = 4'($urandom);
      r = $urandom_range(0, 7);
      if (r == 0) begin
         t = 6'd0;
         s = 4'd0;
      end else if (r == 1) begin
         t = 6'd63;
         s = 4'd15;
      end
      queue_word(gcr_pkg::FUNC_START, t, s, 8'($urandom), 1'b0);
      counted++;
      reads = 0;
      while (reads < reads_wanted) begin
         r = $urandom_range(0, 99);
         if (r < 80 || r >= 98) begin
            queue_word(gcr_pkg::FUNC_READ, 6'($urandom), 4'($urandom), 8'($urandom),
                       (r >= 98) && !calm);
            reads++;
            counted++;
         end else if (r < 95) begin
            queue_word(gcr_pkg::FUNC_LOAD, 6'($urandom), 4'($urandom), 8'($urandom), 1'b0);
            counted++;
         end else begin
            queue_word(FUNC_UNUSED, 6'($urandom), 4'($urandom), 8'($urandom), 1'b0);
         end
      end
   endtask

   // all words in and out, then let the pipe settle
   task automatic wait_idle();
      while (items_taken != items_queued || reads_issued != nibbles_seen)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_volume(input logic [7:0] v);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int         counted;
      logic [7:0] d;
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;

      // address field straight out of reset: track 0, sector 0, volume 254
      for (int i = 0; i < 20; i++) begin
         if (i == 3)
            queue_word(FUNC_UNUSED, 6'h3F, 4'hF, 8'hFF, 1'b0);
         queue_word(gcr_pkg::FUNC_READ, 6'($urandom), 4'($urandom), 8'($urandom), 1'b0);
      end

      // full sector at the top track and sector, three loads past the end
      queue_word(gcr_pkg::FUNC_START, 6'd63, 4'd15, 8'h00, 1'b0);
      for (int i = 0; i < STORE_BYTES + 3; i++) begin
         d = (i % 43 == 0) ? 8'hFF : (i % 37 == 0) ? 8'h00 : 8'($urandom);
         queue_word(gcr_pkg::FUNC_LOAD, 6'($urandom), 4'($urandom), d, 1'b0);
      end
      for (int i = 0; i < NIBBLES_PER_SECTOR + 2; i++) begin
         if (i == 200)
            queue_word(FUNC_UNUSED, 6'h00, 4'h0, 8'h00, 1'b0);
         queue_word(gcr_pkg::FUNC_READ, 6'($urandom), 4'($urandom), 8'($urandom), i == 0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_volume(8'h00);
      counted = 0;
      while (counted < 60)
         queue_sector_pass($urandom_range(5, 40), counted);

      write_volume(8'hFF);
      counted = 0;
      while (counted < 50)
         queue_sector_pass($urandom_range(5, 40), counted);

      write_volume(8'($urandom_range(1, 253)));
      calm = 1'b1;
      counted = 0;
      while (counted < 40)
         queue_sector_pass($urandom_range(5, 40), counted);

      wait_idle();
      if (nibbles_due.size() != 0)
         report_mismatch($sformatf("%0d nibbles never arrived", nibbles_due.size()));

      $display("Run: %0d request words, %0d nibbles checked, %0d sector starts,",
               items_taken, nibbles_seen, starts_seen);
      $display("     %0d full passes to the end of sector, 4 volume settings, %0d errors.",
               wraps_seen, error_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
hdl/gcr_pkg.sv
hdl/gcr_req_if.sv
hdl/gcr_rsp_if.sv
hdl/gcr_sector_store.sv
hdl/gcr_six_and_two_sector_encoder_core.sv
tb/gcr_six_and_two_sector_encoder_core_tb.sv
